[rtl/core/touch_boost_controller_defines.svh]
// ---------------------------------------------------------------------------
// Touch boost controller assertion macros.
// Each macro checks one property on the rising clock edge, with reset
// masking. Setting NO_ASSERTIONS leaves the macros empty.
// ---------------------------------------------------------------------------
`ifndef TOUCH_BOOST_CONTROLLER_DEFINES_SVH
`define TOUCH_BOOST_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TBC_ASSERT_SAME(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("touch boost assertion failed");
`define TBC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("touch boost assertion failed");
`else
`define TBC_ASSERT_SAME(lbl, ck, rn, ante, cons)
`define TBC_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

[rtl/core/tbc_pkg.sv]
// ---------------------------------------------------------------------------
// Touch boost controller package.
// Field widths, event codes, floor levels and the structs shared by the
// modules of the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tbc_pkg;

	localparam int TimerW   = 15;
	localparam int MhzW     = 12;
	localparam int LevelW   = 2;
	localparam int EvTypeW  = 5;
	localparam int EvCodeW  = 10;
	localparam int EvValueW = 32;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 15;
	localparam int InDataW  = 48;
	localparam int OutDataW = 16;

	localparam logic [EvTypeW-1:0] EVT_KEY = 5'd1;
	localparam logic [EvTypeW-1:0] EVT_ABS = 5'd3;

	localparam logic [EvCodeW-1:0] CODE_TOUCH_BUTTON = 10'd330;
	localparam logic [EvCodeW-1:0] CODE_TRACKING_ID  = 10'd57;
	localparam logic [EvCodeW-1:0] CODE_POSITION_X   = 10'd53;

	localparam logic [LevelW-1:0] LEVEL_NONE = 2'd0;
	localparam logic [LevelW-1:0] LEVEL_MID  = 2'd1;
	localparam logic [LevelW-1:0] LEVEL_FULL = 2'd2;

	localparam logic [CfgIdxW-1:0] REG_MID_DELAY = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_HOLD      = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_GPU_MHZ   = 2'd2;

	localparam logic [TimerW-1:0] MID_DELAY_RST = 15'd500;
	localparam logic [TimerW-1:0] HOLD_RST      = 15'd2000;
	localparam logic [MhzW-1:0]   GPU_MHZ_RST   = 12'd550;

	typedef struct packed {
		logic                       req_type;
		logic [EvTypeW-1:0]         event_type;
		logic [EvCodeW-1:0]         event_code;
		logic signed [EvValueW-1:0] event_value;
	} item_t;

	typedef struct packed {
		logic              is_mid;
		logic              is_boosted;
		logic [MhzW-1:0]   gpu_floor_mhz;
		logic [LevelW-1:0] cpu_floor_level;
	} result_t;

	typedef struct packed {
		logic [TimerW-1:0] mid_delay_ms;
		logic [TimerW-1:0] hold_ms;
		logic [MhzW-1:0]   gpu_boost_mhz;
	} cfg_t;

endpackage

`default_nettype wire

[rtl/core/touch_boost_controller.sv]
// Path: an accepted word is held in the input register, and its result word is
// then held in the result register, or waits in the input register on a stall.
// Throughput: one word per cycle unless the output stalls; the state update
// is a single pass of next-state logic between the input and result registers.
// Reset: arst_n clears all floors, flags and timers at once and loads the
// registers with 500 ms mid delay, 2000 ms hold and a 550 MHz GPU boost frequency.
// ---------------------------------------------------------------------------
// Touch boost controller top level.
// Registers input words, applies them to the boost state and registers the
// resulting CPU and GPU floors for the output stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "touch_boost_controller_defines.svh"

module touch_boost_controller (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration write port.
	input  wire logic                          cfg_we,
	input  wire logic [tbc_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [tbc_pkg::CfgDataW-1:0]  cfg_data,
	// Input stream.
	input  wire logic                          s_axis_tvalid,
	output      logic                          s_axis_tready,
	// event_type [4:0], event_code [14:5], event_value [46:15], zero [47]
	input  wire logic [tbc_pkg::InDataW-1:0]   s_axis_tdata,
	// req_type [0]
	input  wire logic                          s_axis_tuser,
	// Output stream.
	output      logic                          m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// cpu_floor_level [1:0], gpu_floor_mhz [13:2], is_boosted [14], is_mid [15]
	output      logic [tbc_pkg::OutDataW-1:0]  m_axis_tdata
);

	tbc_pkg::cfg_t    cfg;
	tbc_pkg::item_t   item_s1;
	tbc_pkg::result_t result_d;
	tbc_pkg::result_t result_q;
	logic             valid_s1;
	logic             out_valid_q;
	logic             advance;

	tbc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// A word moves on when the result register is free or being emptied.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.req_type    <= s_axis_tuser;
			item_s1.event_type  <= s_axis_tdata[4:0];
			item_s1.event_code  <= s_axis_tdata[14:5];
			item_s1.event_value <= s_axis_tdata[46:15];
		end
	end

	tbc_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = result_q;

	`TBC_ASSERT_SAME(a_mid_needs_boost, clk, arst_n, out_valid_q,
		!result_q.is_mid || result_q.is_boosted)
	`TBC_ASSERT_SAME(a_level_matches_flags, clk, arst_n, out_valid_q,
		(result_q.is_boosted == (result_q.cpu_floor_level != tbc_pkg::LEVEL_NONE)) &&
		(result_q.is_mid == (result_q.cpu_floor_level == tbc_pkg::LEVEL_MID)))
	`TBC_ASSERT_NEXT(a_advance_gives_result, clk, arst_n, advance, out_valid_q)
	`TBC_ASSERT_NEXT(a_stalled_word_kept, clk, arst_n, valid_s1 && !advance, valid_s1)

endmodule

`default_nettype wire

[rtl/core/tbc_cfg_regs.sv]
// ---------------------------------------------------------------------------
// Touch boost configuration registers.
// Holds the mid delay, hold time and GPU boost frequency written through
// the plain write port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbc_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [tbc_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [tbc_pkg::CfgDataW-1:0]  cfg_data,
	output tbc_pkg::cfg_t                      cfg
);

	tbc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mid_delay_ms  <= tbc_pkg::MID_DELAY_RST;
			cfg_q.hold_ms       <= tbc_pkg::HOLD_RST;
			cfg_q.gpu_boost_mhz <= tbc_pkg::GPU_MHZ_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tbc_pkg::REG_MID_DELAY: cfg_q.mid_delay_ms  <= cfg_data;
				tbc_pkg::REG_HOLD:      cfg_q.hold_ms       <= cfg_data;
				tbc_pkg::REG_GPU_MHZ:   cfg_q.gpu_boost_mhz <= cfg_data[tbc_pkg::MhzW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/core/tbc_state.sv]
// ---------------------------------------------------------------------------
// Touch boost state update.
// Holds the boost flags, both timers and the current floors, and computes
// their next values for one word. The result shows the state after the word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbc_state (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          fire,
	input  wire tbc_pkg::item_t item,
	input  wire tbc_pkg::cfg_t  cfg,
	output tbc_pkg::result_t   result
);

	logic                          boost_q, mid_q, mid_armed_q, hold_armed_q;
	logic [tbc_pkg::TimerW-1:0]    mid_left_q, hold_left_q;
	logic [tbc_pkg::LevelW-1:0]    cpu_q;
	logic [tbc_pkg::MhzW-1:0]      gpu_q;

	logic                          boost_d, mid_d, mid_armed_d, hold_armed_d;
	logic [tbc_pkg::TimerW-1:0]    mid_left_d, hold_left_d;
	logic [tbc_pkg::LevelW-1:0]    cpu_d;
	logic [tbc_pkg::MhzW-1:0]      gpu_d;

	logic is_touch_key, is_track_id, is_pos_x;
	logic do_press, do_lift, mid_end, hold_end;

	assign is_touch_key = (item.event_type == tbc_pkg::EVT_KEY) &&
		(item.event_code == tbc_pkg::CODE_TOUCH_BUTTON);
	assign is_track_id  = (item.event_type == tbc_pkg::EVT_ABS) &&
		(item.event_code == tbc_pkg::CODE_TRACKING_ID);
	assign is_pos_x     = (item.event_type == tbc_pkg::EVT_ABS) &&
		(item.event_code == tbc_pkg::CODE_POSITION_X);

	// A tracking id of zero or more is a finger going down.
	assign do_press = !item.req_type && ((is_touch_key && (item.event_value != '0)) ||
		(is_track_id && !item.event_value[tbc_pkg::EvValueW-1]));
	assign do_lift  = !item.req_type && ((is_touch_key && (item.event_value == '0)) ||
		(is_track_id && item.event_value[tbc_pkg::EvValueW-1]));

	// A timer ends on the tick that finds one or zero ticks left.
	assign mid_end  = item.req_type && mid_armed_q && (mid_left_q <= 15'd1);
	assign hold_end = item.req_type && hold_armed_q && (hold_left_q <= 15'd1);

	always_comb begin
		boost_d      = boost_q;
		mid_d        = mid_q;
		mid_armed_d  = mid_armed_q;
		hold_armed_d = hold_armed_q;
		mid_left_d   = mid_left_q;
		hold_left_d  = hold_left_q;
		cpu_d        = cpu_q;
		gpu_d        = gpu_q;
		if (item.req_type) begin
			if (mid_end) begin
				mid_armed_d = 1'b0;
				mid_left_d  = '0;
				if (boost_q && !mid_q) begin
					mid_d = 1'b1;
					cpu_d = tbc_pkg::LEVEL_MID;
				end
			end else if (mid_armed_q) begin
				mid_left_d = mid_left_q - 15'd1;
			end
			if (hold_end) begin
				hold_armed_d = 1'b0;
				hold_left_d  = '0;
				if (boost_q) begin
					boost_d = 1'b0;
					mid_d   = 1'b0;
					gpu_d   = '0;
					cpu_d   = tbc_pkg::LEVEL_NONE;
				end
			end else if (hold_armed_q) begin
				hold_left_d = hold_left_q - 15'd1;
			end
		end else if (do_press) begin
			boost_d      = 1'b1;
			mid_d        = 1'b0;
			hold_armed_d = 1'b0;
			cpu_d        = tbc_pkg::LEVEL_FULL;
			gpu_d        = cfg.gpu_boost_mhz;
			mid_armed_d  = 1'b1;
			mid_left_d   = cfg.mid_delay_ms;
		end else if (do_lift) begin
			mid_armed_d  = 1'b0;
			hold_armed_d = 1'b1;
			hold_left_d  = cfg.hold_ms;
		end else if (is_pos_x && boost_q) begin
			hold_armed_d = 1'b0;
			mid_armed_d  = 1'b1;
			mid_left_d   = cfg.mid_delay_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boost_q      <= 1'b0;
			mid_q        <= 1'b0;
			mid_armed_q  <= 1'b0;
			hold_armed_q <= 1'b0;
			mid_left_q   <= '0;
			hold_left_q  <= '0;
			cpu_q        <= tbc_pkg::LEVEL_NONE;
			gpu_q        <= '0;
		end else if (fire) begin
			boost_q      <= boost_d;
			mid_q        <= mid_d;
			mid_armed_q  <= mid_armed_d;
			hold_armed_q <= hold_armed_d;
			mid_left_q   <= mid_left_d;
			hold_left_q  <= hold_left_d;
			cpu_q        <= cpu_d;
			gpu_q        <= gpu_d;
		end
	end

	assign result.cpu_floor_level = cpu_d;
	assign result.gpu_floor_mhz   = gpu_d;
	assign result.is_boosted      = boost_d;
	assign result.is_mid          = mid_d;

endmodule

`default_nettype wire
